>>> sv/region_grow_mask_assert.svh
// Assertion macros for the checker file of the region grow block.
`ifndef REGION_GROW_MASK_ASSERT_SVH
`define REGION_GROW_MASK_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RGM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define RGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/rgm_pkg.sv
// Package with the types and codes of the region grow block.
package rgm_pkg;
   localparam int unsigned ROW_W = 6;
   localparam int unsigned COL_W = 6;
   localparam int unsigned PIX_W = 8;
   localparam int unsigned CNT_W = 13;
   localparam int unsigned DELTA_W = 9;

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_GROW = 2'd1,
      MODE_READ = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      REG_SEED_THRESHOLD = 1'b0,
      REG_GROW_DELTA     = 1'b1
   } reg_index_type;

   localparam logic [PIX_W-1:0] SEED_THRESHOLD_RESET = 8'd140;
   localparam logic [DELTA_W-1:0] GROW_DELTA_RESET = 9'd10;

   typedef struct packed {
      logic [1:0]       mode;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic             mask_bit;
      logic [CNT_W-1:0] region_count;
   } rsp_type;

   typedef struct packed {
      logic        index;
      logic [15:0] data;
   } csr_type;
endpackage

>>> sv/rgm_if.sv
// Valid/ready channel interfaces of the region grow block.
interface rgm_req_if;
   logic              valid;
   logic              ready;
   rgm_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rgm_rsp_if;
   logic              valid;
   logic              ready;
   rgm_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rgm_csr_if;
   logic              valid;
   logic              ready;
   rgm_pkg::csr_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/region_grow_mask.sv
// Region grow block: frame store, seed scan and breadth-first grow engine.
// Channels: req_ (mode, row, col, pixel), rsp_ (mask_bit, region_count) and
// csr_ (index 0 seed threshold, index 1 grow delta), all valid/ready.
// A load writes the frame store (only inside the image) and gives no response.
// A read goes through a mask memory read, then the response register.
// A grow first clears the mask memory (one entry a cycle), then scans all
// pixels for seeds (each through an image read), then pops each frontier
// entry (queue read, then current pixel read) and tests up to four neighbors,
// reading image and mask for a neighbor inside the image and skipping one
// outside it. The image memory has a single read port, which paces the grow.
// Reset clears the controller and the count, presets the registers; the mask
// reads as zero after reset because the first grow clears it and reads
// before any grow are answered from a cleared flag. A stalled response holds
// its register; a new request is accepted only once the response is taken.
module region_grow_mask #(
   parameter int unsigned IMG_WIDTH  = 64,
   parameter int unsigned IMG_HEIGHT = 64
) (
   input logic clock,
   input logic reset,
   rgm_req_if.sink   req,
   rgm_rsp_if.source rsp,
   rgm_csr_if.sink   csr
);
   localparam int unsigned NPIX = IMG_WIDTH * IMG_HEIGHT;
   localparam int unsigned AW = $clog2(NPIX);
   localparam int unsigned QW = AW + 1;
   localparam int unsigned CW = $clog2(IMG_WIDTH);
   localparam int unsigned RW = $clog2(IMG_HEIGHT);
   localparam int unsigned EW = RW + CW;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_READ   = 11'b00000000010,
      ST_CLEAR  = 11'b00000000100,
      ST_SREQ   = 11'b00000001000,
      ST_SCHK   = 11'b00000010000,
      ST_POP    = 11'b00000100000,
      ST_PWAIT  = 11'b00001000000,
      ST_CREQ   = 11'b00010000000,
      ST_NREQ   = 11'b00100000000,
      ST_NCHK   = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] image_mem [NPIX];
   logic       mask_mem [NPIX];
   logic [EW-1:0] queue_mem [NPIX];

   logic [7:0]          thr_ff;
   logic [8:0]          delta_ff;
   logic [QW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [QW-1:0]       count_ff, count_in;
   logic [QW-1:0]       scan_ff, scan_in;
   logic [RW-1:0]       scan_r_ff, scan_r_in, cur_r_ff, cur_r_in;
   logic [CW-1:0]       scan_c_ff, scan_c_in, cur_c_ff, cur_c_in;
   logic [EW-1:0]       nb_rc_ff, nb_rc_in;
   logic [AW-1:0]       cur_ff, cur_in, nb_ff, nb_in;
   logic [7:0]          cur_pix_ff, cur_pix_in;
   logic [1:0]          dir_ff, dir_in;
   logic                grown_ff, grown_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rgm_pkg::rsp_type    rsp_ff, rsp_in;

   // Memory port controls.
   logic          img_we, img_re, msk_we, msk_re, msk_wd, q_we, q_re;
   logic [AW-1:0] img_wa, img_ra, msk_a, q_wa, q_ra;
   logic [7:0]    img_wd, img_rd_ff;
   logic          msk_rd_ff;
   logic [EW-1:0] q_rd_ff;

   logic          in_img;
   logic [AW-1:0] req_addr;
   logic [AW-1:0] q_addr;
   logic [RW-1:0] nb_r;
   logic [CW-1:0] nb_c;
   logic          nb_ok;
   logic [AW-1:0] nb_addr;
   logic [8:0]    diff;

   // Queue entries hold row and column, so no division is needed on a pop.
   always_comb begin
      in_img = (32'(req.payload.row) < IMG_HEIGHT) && (32'(req.payload.col) < IMG_WIDTH);
      req_addr = AW'(32'(req.payload.row) * IMG_WIDTH + 32'(req.payload.col));
      q_addr = AW'(32'(q_rd_ff[EW-1:CW]) * IMG_WIDTH + 32'(q_rd_ff[CW-1:0]));
      diff = (cur_pix_ff > img_rd_ff) ? 9'(cur_pix_ff - img_rd_ff)
                                      : 9'(img_rd_ff - cur_pix_ff);
      nb_ok = 1'b0;
      nb_addr = cur_ff;
      nb_r = cur_r_ff;
      nb_c = cur_c_ff;
      case (dir_ff)
         2'd0: begin
            nb_ok = 32'(cur_c_ff) + 1 < IMG_WIDTH;
            nb_addr = cur_ff + AW'(1);
            nb_c = cur_c_ff + CW'(1);
         end
         2'd1: begin
            nb_ok = cur_c_ff != '0;
            nb_addr = cur_ff - AW'(1);
            nb_c = cur_c_ff - CW'(1);
         end
         2'd2: begin
            nb_ok = 32'(cur_r_ff) + 1 < IMG_HEIGHT;
            nb_addr = cur_ff + AW'(IMG_WIDTH);
            nb_r = cur_r_ff + RW'(1);
         end
         default: begin
            nb_ok = cur_r_ff != '0;
            nb_addr = cur_ff - AW'(IMG_WIDTH);
            nb_r = cur_r_ff - RW'(1);
         end
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      scan_r_in = scan_r_ff;
      scan_c_in = scan_c_ff;
      cur_in = cur_ff;
      cur_r_in = cur_r_ff;
      cur_c_in = cur_c_ff;
      nb_in = nb_ff;
      nb_rc_in = nb_rc_ff;
      cur_pix_in = cur_pix_ff;
      dir_in = dir_ff;
      grown_in = grown_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      img_we = 1'b0; img_wa = req_addr; img_wd = req.payload.pixel;
      img_re = 1'b0; img_ra = AW'(scan_ff);
      msk_we = 1'b0; msk_re = 1'b0; msk_a = req_addr; msk_wd = 1'b0;
      q_we = 1'b0; q_wa = AW'(tail_ff); q_re = 1'b0; q_ra = AW'(head_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               case (req.payload.mode)
                  rgm_pkg::MODE_LOAD: begin
                     img_we = in_img;
                  end
                  rgm_pkg::MODE_GROW: begin
                     scan_in = '0;
                     state_in = ST_CLEAR;
                  end
                  rgm_pkg::MODE_READ: begin
                     msk_re = 1'b1;
                     cur_pix_in = {7'd0, in_img};
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in.mask_bit = cur_pix_ff[0] && grown_ff && msk_rd_ff;
            rsp_in.region_count = rgm_pkg::CNT_W'(count_ff);
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            msk_we = 1'b1; msk_a = AW'(scan_ff); msk_wd = 1'b0;
            if (scan_ff == QW'(NPIX - 1)) begin
               scan_in = '0; head_in = '0; tail_in = '0; count_in = '0;
               scan_r_in = '0; scan_c_in = '0;
               grown_in = 1'b1;
               state_in = ST_SREQ;
            end else begin
               scan_in = scan_ff + QW'(1);
            end
         end
         ST_SREQ: begin
            img_re = 1'b1; img_ra = AW'(scan_ff);
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (img_rd_ff > thr_ff) begin
               msk_we = 1'b1; msk_a = AW'(scan_ff); msk_wd = 1'b1;
               q_we = 1'b1; q_wa = AW'(tail_ff);
               tail_in = tail_ff + QW'(1);
               count_in = count_ff + QW'(1);
            end
            if (scan_ff == QW'(NPIX - 1)) begin
               state_in = ST_POP;
            end else begin
               scan_in = scan_ff + QW'(1);
               if (32'(scan_c_ff) == IMG_WIDTH - 1) begin
                  scan_c_in = '0;
                  scan_r_in = scan_r_ff + RW'(1);
               end else begin
                  scan_c_in = scan_c_ff + CW'(1);
               end
               state_in = ST_SREQ;
            end
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_DONE;
            end else begin
               q_re = 1'b1;
               head_in = head_ff + QW'(1);
               state_in = ST_PWAIT;
            end
         end
         ST_PWAIT: begin
            cur_in = q_addr;
            cur_r_in = q_rd_ff[EW-1:CW];
            cur_c_in = q_rd_ff[CW-1:0];
            img_re = 1'b1; img_ra = q_addr;
            dir_in = 2'd0;
            state_in = ST_CREQ;
         end
         ST_CREQ: begin
            cur_pix_in = img_rd_ff;
            state_in = ST_NREQ;
         end
         ST_NREQ: begin
            if (nb_ok) begin
               img_re = 1'b1; img_ra = nb_addr;
               msk_re = 1'b1; msk_a = nb_addr;
               nb_in = nb_addr;
               nb_rc_in = {nb_r, nb_c};
               state_in = ST_NCHK;
            end else if (dir_ff == 2'd3) begin
               state_in = ST_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         ST_NCHK: begin
            if (diff < delta_ff && !msk_rd_ff && tail_ff < QW'(NPIX)) begin
               msk_we = 1'b1; msk_a = nb_ff; msk_wd = 1'b1;
               q_we = 1'b1; q_wa = AW'(tail_ff);
               tail_in = tail_ff + QW'(1);
               count_in = count_ff + QW'(1);
            end
            if (dir_ff == 2'd3) begin
               state_in = ST_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
               state_in = ST_NREQ;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.mask_bit = 1'b0;
            rsp_in.region_count = rgm_pkg::CNT_W'(count_ff);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Queue write data is the pixel just marked: scan position or neighbor.
   logic [EW-1:0] q_wd;
   assign q_wd = (state_ff == ST_SCHK) ? {scan_r_ff, scan_c_ff} : nb_rc_ff;

   always_ff @(posedge clock) begin
      if (img_we) image_mem[img_wa] <= img_wd;
      if (img_re) img_rd_ff <= image_mem[img_ra];
   end

   always_ff @(posedge clock) begin
      if (msk_we) mask_mem[msk_a] <= msk_wd;
      if (msk_re) msk_rd_ff <= mask_mem[msk_a];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_wa] <= q_wd;
      if (q_re) q_rd_ff <= queue_mem[q_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff <= rgm_pkg::SEED_THRESHOLD_RESET;
         delta_ff <= rgm_pkg::GROW_DELTA_RESET;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         grown_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         grown_ff <= grown_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            case (csr.payload.index)
               rgm_pkg::REG_SEED_THRESHOLD: thr_ff <= csr.payload.data[7:0];
               rgm_pkg::REG_GROW_DELTA: delta_ff <= csr.payload.data[8:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      scan_r_ff <= scan_r_in;
      scan_c_ff <= scan_c_in;
      cur_ff <= cur_in;
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      nb_ff <= nb_in;
      nb_rc_ff <= nb_rc_in;
      cur_pix_ff <= cur_pix_in;
      dir_ff <= dir_in;
      rsp_ff <= rsp_in;
   end
endmodule

>>> sv/rgm_checker.sv
// Port checker of the region grow block and its bind.
`include "region_grow_mask_assert.svh"
module rgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_mask_bit,
   input logic [12:0] rsp_region_count
);
   `RGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_region_count) && $stable(rsp_mask_bit), "response dropped or changed while stalled")
   `RGM_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "request accepted while a response waits")
   `RGM_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_region_count <= 13'd4096, "region count out of range")
   `RGM_ASSERT_NEXT(a_load_silent, clock, reset, req_valid && req_ready && req_mode == rgm_pkg::MODE_LOAD, !rsp_valid, "load produced a response")
endmodule

bind region_grow_mask rgm_checker u_rgm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .req_mode(req.payload.mode),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_mask_bit(rsp.payload.mask_bit),
   .rsp_region_count(rsp.payload.region_count)
);
